/* sv/rpm_pkg.sv */
// Shared widths, codes, reset values and reciprocal constants of the ripple meter.
package rpm_pkg;

  localparam int MODE_W     = 2;
  localparam int SAMPLE_W   = 12;
  localparam int VALUE_W    = 13;
  localparam int WLEN_W     = 16;
  localparam int OFFS_W     = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [MODE_W-1:0] MODE_POS  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NEG  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LVL  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

  // register index, taken from paddr[2]
  localparam logic REG_WINDOW_LEN  = 1'b0;
  localparam logic REG_COMP_OFFSET = 1'b1;

  localparam logic [WLEN_W-1:0] WINDOW_LEN_RST  = 16'd2000;
  localparam logic [OFFS_W-1:0] COMP_OFFSET_RST = 8'd169;

  // floor(t / 3) = (t * RECIP3) >> 20 for t < 2^19
  localparam int               RECIP3_W     = 19;
  localparam logic [18:0]      RECIP3       = 19'd349526;
  localparam int               RECIP3_SHIFT = 20;

  // floor(y / 125) = (y * RECIP125) >> 24 for y < 2^18
  localparam int               RECIP125_W     = 18;
  localparam logic [17:0]      RECIP125       = 18'd134218;
  localparam int               RECIP125_SHIFT = 24;

  // ceil(x / 125) = floor((x + 124) / 125)
  localparam int               CORR_BIAS = 124;

  typedef struct packed {
    logic [WLEN_W-1:0] window_len;
    logic [OFFS_W-1:0] comp_offset;
  } cfg_t;

endpackage

/* sv/rpm_if.sv */
// Valid/ready channel interfaces for samples in and results out.
interface rpm_smp_if;
  import rpm_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output mode, output sample, input ready);
  modport sink   (input valid, input mode, input sample, output ready);
endinterface

interface rpm_res_if;
  import rpm_pkg::*;

  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  channel;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output channel, output value, input ready);
  modport sink   (input valid, input channel, input value, output ready);
endinterface

/* sv/ripple_peak_and_rms_meter_unit.sv */
// Top level of the ripple peak and RMS meter: sequencer, datapath and ports.
//
//   port       | dir | transfer when          | payload
//   -----------+-----+------------------------+------------------------------
//   smp_i      | in  | valid & ready          | mode (2b), sample (12b)
//   res_o      | out | valid & ready          | channel (2b), value (13b)
//   APB        | in  | psel & penable & pwrite| paddr 0: window_len, 4: comp_offset
//
// Flow. A sample that does not close a batch is taken straight from idle (level
// samples pass through the accumulate state). A peak sample that closes a batch is
// paced by the one-entry-per-cycle scan of the maxima RAM. A level sample that
// closes a batch is paced by the subtractor settling one root bit per cycle.
// Reset clears all counters, peaks and the square sum; the maxima RAM needs no
// clearing. A waiting result holds the next batch close in its last cycle until
// res_o frees, stalling the input.
module ripple_peak_and_rms_meter_unit #(
  parameter int BATCH_LEN   = 8,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rpm_smp_if.sink                        smp_i,
  rpm_res_if.source                      res_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rpm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rpm_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rpm_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import rpm_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int SQ   = 2 * SB;
  localparam int CW   = $clog2(BATCH_LEN);
  localparam int SUMW = SQ + CW;
  localparam int UW   = SUMW + 1;
  localparam int STW  = $clog2(((SB > BATCH_LEN) ? SB : BATCH_LEN) + 1);
  localparam int AW   = $clog2(2 * BATCH_LEN);
  localparam int T3W  = SB + 2;
  localparam int P1W  = T3W + RECIP3_W;
  localparam int XW   = SB + 1;
  localparam int P2W  = XW + RECIP125_W;
  localparam int DW   = P2W - RECIP125_SHIFT;

  // top root weight, scaled by the batch length
  localparam logic [SUMW-1:0] BT_INIT = SUMW'(BATCH_LEN) << (2 * (SB - 1));

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ACC   = 4'd1;
  localparam logic [3:0] S_ROOT  = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_ADD3  = 4'd5;
  localparam logic [3:0] S_DIV3  = 4'd6;
  localparam logic [3:0] S_CORR1 = 4'd7;
  localparam logic [3:0] S_CORR2 = 4'd8;

  cfg_t cfg;

  // control state
  logic [3:0]        state_q, state_d;
  logic [WLEN_W-1:0] win_cnt_q [2];
  logic [WLEN_W-1:0] win_cnt_d [2];
  logic [SB-1:0]     win_peak_q [2];
  logic [SB-1:0]     win_peak_d [2];
  logic [CW-1:0]     pk_bcnt_q [2];
  logic [CW-1:0]     pk_bcnt_d [2];
  logic [CW-1:0]     lvl_bcnt_q, lvl_bcnt_d;
  logic [SUMW-1:0]   sum_q, sum_d;
  logic [STW-1:0]    step_q, step_d;
  logic              ovalid_q, ovalid_d;

  // working registers
  logic [SQ-1:0]      sq_q, sq_d;
  logic [SUMW-1:0]    dv_q, dv_d;
  logic [SUMW-1:0]    rm_q, rm_d;
  logic [SUMW-1:0]    bt_q, bt_d;
  logic [SB-1:0]      root_q, root_d;
  logic [SB-1:0]      top_a_q, top_a_d, top_b_q, top_b_d, top_c_q, top_c_d;
  logic [T3W-1:0]     t3_q, t3_d;
  logic [SB-1:0]      x_q, x_d;
  logic [DW-1:0]      dec_q, dec_d;
  logic [MODE_W-1:0]  ch_q, ch_d;
  logic [MODE_W-1:0]  och_q, och_d;
  logic [VALUE_W-1:0] oval_q, oval_d;

  // datapath wires
  logic [SB-1:0]     smp;
  logic              pk;
  logic [SB-1:0]     peak_new;
  logic [WLEN_W:0]   cnt_next;
  logic [CW:0]       pk_bnext;
  logic [CW:0]       lvl_bnext;
  logic [SUMW-1:0]   sum_new;
  logic [P1W-1:0]    prod1;
  logic [P2W-1:0]    prod2;
  logic [UW-1:0]     sub_a, sub_b, sub_diff;
  logic              sub_ge;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [SB-1:0]     ram_rdata;
  logic [AW-1:0]     wr_base, rd_base;

  rpm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // trial unit: remaining sum against the scaled trial square, one root bit per cycle
  rpm_sub_unit #(.W(UW)) u_sub (
    .a_i    (sub_a),
    .b_i    (sub_b),
    .diff_o (sub_diff),
    .ge_o   (sub_ge)
  );

  // window maxima, channel 0 in the low half, channel 1 in the high half
  rpm_ram #(.W(SB), .D(2 * BATCH_LEN)) u_maxima (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (peak_new),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign smp       = SB'(smp_i.sample);
  assign pk        = smp_i.mode[0];
  assign peak_new  = (smp > win_peak_q[pk]) ? smp : win_peak_q[pk];
  assign cnt_next  = {1'b0, win_cnt_q[pk]} + (WLEN_W + 1)'(1);
  assign pk_bnext  = {1'b0, pk_bcnt_q[pk]} + (CW + 1)'(1);
  assign lvl_bnext = {1'b0, lvl_bcnt_q} + (CW + 1)'(1);
  assign sum_new   = sum_q + SUMW'(sq_q);
  assign wr_base   = pk ? AW'(BATCH_LEN) : '0;
  assign rd_base   = ch_q[0] ? AW'(BATCH_LEN) : '0;
  assign ram_waddr = wr_base + AW'(pk_bcnt_q[pk]);
  assign ram_raddr = rd_base + AW'(step_q[CW-1:0]);
  assign prod1     = t3_q * RECIP3;
  assign prod2     = (XW'(x_q) + XW'(CORR_BIAS)) * RECIP125;
  assign sub_a     = {1'b0, dv_q};
  assign sub_b     = {1'b0, rm_q} + {1'b0, bt_q};

  assign smp_i.ready   = (state_q == S_IDLE);
  assign res_o.valid   = ovalid_q;
  assign res_o.channel = och_q;
  assign res_o.value   = oval_q;

  always_comb begin
    state_d    = state_q;
    win_cnt_d  = win_cnt_q;
    win_peak_d = win_peak_q;
    pk_bcnt_d  = pk_bcnt_q;
    lvl_bcnt_d = lvl_bcnt_q;
    sum_d      = sum_q;
    step_d     = step_q;
    ovalid_d   = ovalid_q;
    sq_d       = sq_q;
    dv_d       = dv_q;
    rm_d       = rm_q;
    bt_d       = bt_q;
    root_d     = root_q;
    top_a_d    = top_a_q;
    top_b_d    = top_b_q;
    top_c_d    = top_c_q;
    t3_d       = t3_q;
    x_d        = x_q;
    dec_d      = dec_q;
    ch_d       = ch_q;
    och_d      = och_q;
    oval_d     = oval_q;
    ram_we     = 1'b0;

    // drop the held result once the sink takes it
    if (ovalid_q && res_o.ready) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (smp_i.valid) begin
          unique case (smp_i.mode)
            MODE_POS, MODE_NEG: begin
              if (cnt_next >= {1'b0, cfg.window_len}) begin
                // window closes: store its maximum, restart the window
                ram_we         = 1'b1;
                win_peak_d[pk] = '0;
                win_cnt_d[pk]  = '0;
                if (pk_bnext == (CW + 1)'(BATCH_LEN)) begin
                  pk_bcnt_d[pk] = '0;
                  ch_d          = smp_i.mode;
                  step_d        = '0;
                  top_a_d       = '0;
                  top_b_d       = '0;
                  top_c_d       = '0;
                  state_d       = S_SCAN;
                end else begin
                  pk_bcnt_d[pk] = pk_bnext[CW-1:0];
                end
              end else begin
                win_peak_d[pk] = peak_new;
                win_cnt_d[pk]  = cnt_next[WLEN_W-1:0];
              end
            end
            MODE_LVL: begin
              sq_d    = SQ'(smp) * SQ'(smp);
              state_d = S_ACC;
            end
            default: begin
            end
          endcase
        end
      end

      S_ACC: begin
        if (lvl_bnext == (CW + 1)'(BATCH_LEN)) begin
          dv_d       = sum_new;
          sum_d      = '0;
          lvl_bcnt_d = '0;
          rm_d       = '0;
          bt_d       = BT_INIT;
          root_d     = '0;
          step_d     = '0;
          ch_d       = MODE_LVL;
          state_d    = S_ROOT;
        end else begin
          sum_d      = sum_new;
          lvl_bcnt_d = lvl_bnext[CW-1:0];
          state_d    = S_IDLE;
        end
      end

      S_ROOT: begin
        // digit-by-digit root of sum / BATCH_LEN: weigh the whole sum against
        // BATCH_LEN times the trial square, so no quotient is ever formed
        dv_d   = sub_ge ? sub_diff[SUMW-1:0] : dv_q;
        rm_d   = sub_ge ? ((rm_q >> 1) + bt_q) : (rm_q >> 1);
        bt_d   = bt_q >> 2;
        root_d = {root_q[SB-2:0], sub_ge};
        if (step_q == STW'(SB - 1)) begin
          x_d     = {root_q[SB-2:0], sub_ge};
          state_d = S_CORR1;
        end else begin
          step_d = step_q + STW'(1);
        end
      end

      S_SCAN: begin
        // read data is registered and arrives in the cycle after its address
        if (step_q != '0) begin
          priority if (ram_rdata > top_a_q) begin
            top_c_d = top_b_q;
            top_b_d = top_a_q;
            top_a_d = ram_rdata;
          end else if (ram_rdata > top_b_q) begin
            top_c_d = top_b_q;
            top_b_d = ram_rdata;
          end else if (ram_rdata > top_c_q) begin
            top_c_d = ram_rdata;
          end
        end
        if (step_q == STW'(BATCH_LEN)) begin
          state_d = S_ADD3;
        end else begin
          step_d = step_q + STW'(1);
        end
      end

      S_ADD3: begin
        t3_d    = T3W'(top_a_q) + T3W'(top_b_q) + T3W'(top_c_q);
        state_d = S_DIV3;
      end

      S_DIV3: begin
        x_d     = prod1[RECIP3_SHIFT +: SB];
        state_d = S_CORR1;
      end

      S_CORR1: begin
        dec_d   = prod2[P2W-1:RECIP125_SHIFT];
        state_d = S_CORR2;
      end

      S_CORR2: begin
        // hold until the output register is free
        if (!ovalid_q || res_o.ready) begin
          ovalid_d = 1'b1;
          och_d    = ch_q;
          oval_d   = VALUE_W'(XW'(x_q) + XW'(cfg.comp_offset) - XW'(dec_q));
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      win_cnt_q  <= '{default: '0};
      win_peak_q <= '{default: '0};
      pk_bcnt_q  <= '{default: '0};
      lvl_bcnt_q <= '0;
      sum_q      <= '0;
      step_q     <= '0;
      ovalid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      win_cnt_q  <= win_cnt_d;
      win_peak_q <= win_peak_d;
      pk_bcnt_q  <= pk_bcnt_d;
      lvl_bcnt_q <= lvl_bcnt_d;
      sum_q      <= sum_d;
      step_q     <= step_d;
      ovalid_q   <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q    <= sq_d;
    dv_q    <= dv_d;
    rm_q    <= rm_d;
    bt_q    <= bt_d;
    root_q  <= root_d;
    top_a_q <= top_a_d;
    top_b_q <= top_b_d;
    top_c_q <= top_c_d;
    t3_q    <= t3_d;
    x_q     <= x_d;
    dec_q   <= dec_d;
    ch_q    <= ch_d;
    och_q   <= och_d;
    oval_q  <= oval_d;
  end

endmodule

/* sv/rpm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rpm_ram #(
  parameter int W = 12,
  parameter int D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/rpm_sub_unit.sv */
// Trial subtractor: difference and greater-or-equal flag.
module rpm_sub_unit #(
  parameter int W = 14
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic [W-1:0] diff_o,
  output logic         ge_o
);

  logic [W:0] full;

  assign full   = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = full[W-1:0];
  assign ge_o   = ~full[W];

endmodule

/* sv/rpm_cfg.sv */
// APB configuration registers: window length and offset constant.
module rpm_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rpm_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [rpm_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [rpm_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready,
  output rpm_pkg::cfg_t                       cfg_o
);
  import rpm_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;
  logic wr_en;
  logic reg_idx;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[2];
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_WINDOW_LEN:  cfg_d.window_len  = pwdata[WLEN_W-1:0];
        REG_COMP_OFFSET: cfg_d.comp_offset = pwdata[OFFS_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WINDOW_LEN:  prdata = APB_DATA_W'(cfg_q.window_len);
      REG_COMP_OFFSET: prdata = APB_DATA_W'(cfg_q.comp_offset);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_len  <= WINDOW_LEN_RST;
      cfg_q.comp_offset <= COMP_OFFSET_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
